// File: rtl/sed_pkg.sv
// Shared types and constants of the Sampson epipolar distance block.
package sed_pkg;

    localparam int unsigned COEF_W     = 32;
    localparam int unsigned NUM_COEF   = 9;
    localparam int unsigned DIST_W     = 16;
    localparam int unsigned ONE_SHIFT  = 4;
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned APB_ADDR_W = 6;
    localparam int unsigned REG_IDX_W  = 3;

    localparam logic [DIST_W-1:0] DIST_MAX        = 16'hFFFF;
    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 16'd16;

    localparam logic [REG_IDX_W-1:0] REG_COEF_PAIR_0      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_PAIR_1      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_PAIR_2      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_PAIR_3      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_LAST        = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INLIER_THRESHOLD = 3'd5;

    typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_array_t;

    typedef struct packed {
        logic [15:0] first_x;
        logic [15:0] first_y;
        logic [15:0] second_x;
        logic [15:0] second_y;
    } sed_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              inlier;
        logic              degenerate;
    } sed_out_t;

endpackage

// File: rtl/sampson_epipolar_distance.sv
// Sampson epipolar distance unit: one point correspondence per request, a
// new request every cycle unless a result waits on m_ready. The pipeline has
// six front stages for the epipolar lines and products, one stage per root bit
// in the square-root pipeline, an input stage and one stage per quotient bit in
// the divider, and the output register. The whole pipeline holds while a result
// waits on m_ready. Matrix and threshold are written over APB at byte addresses
// 8*i; the user must write them only while no request is in flight, and the block does not enforce it.
module sampson_epipolar_distance
    import sed_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sed_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sed_out_t              m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int S_W = 68 + 2 * COORD_BITS;
    localparam int MW  = 35 + 2 * COORD_BITS;
    localparam int R_W = S_W / 2;

    logic [APB_DATA_W-1:0] coef_pair_0_reg, coef_pair_1_reg;
    logic [APB_DATA_W-1:0] coef_pair_2_reg, coef_pair_3_reg;
    logic [COEF_W-1:0]     coef_last_reg;
    logic [DIST_W-1:0]     thr_reg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  cfg_we;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_pair_0_reg <= '0;
            coef_pair_1_reg <= '0;
            coef_pair_2_reg <= '0;
            coef_pair_3_reg <= '0;
            coef_last_reg   <= '0;
            thr_reg         <= THRESHOLD_RESET;
        end else if (cfg_we) begin
            case (reg_idx)
                REG_COEF_PAIR_0:      coef_pair_0_reg <= pwdata;
                REG_COEF_PAIR_1:      coef_pair_1_reg <= pwdata;
                REG_COEF_PAIR_2:      coef_pair_2_reg <= pwdata;
                REG_COEF_PAIR_3:      coef_pair_3_reg <= pwdata;
                REG_COEF_LAST:        coef_last_reg   <= pwdata[COEF_W-1:0];
                REG_INLIER_THRESHOLD: thr_reg         <= pwdata[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COEF_PAIR_0:      prdata = coef_pair_0_reg;
            REG_COEF_PAIR_1:      prdata = coef_pair_1_reg;
            REG_COEF_PAIR_2:      prdata = coef_pair_2_reg;
            REG_COEF_PAIR_3:      prdata = coef_pair_3_reg;
            REG_COEF_LAST:        prdata = APB_DATA_W'(coef_last_reg);
            REG_INLIER_THRESHOLD: prdata = APB_DATA_W'(thr_reg);
            default:              prdata = '0;
        endcase
    end

    coef_array_t coef;

    assign coef = {coef_last_reg,
                   coef_pair_3_reg[63:32], coef_pair_3_reg[31:0],
                   coef_pair_2_reg[63:32], coef_pair_2_reg[31:0],
                   coef_pair_1_reg[63:32], coef_pair_1_reg[31:0],
                   coef_pair_0_reg[63:32], coef_pair_0_reg[31:0]};

    logic     en;
    logic     m_valid_reg;
    sed_out_t m_data_reg, m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic           fr_valid;
    logic [S_W-1:0] fr_sum;
    logic [MW-1:0]  fr_rmag;
    logic           fr_degen;

    sed_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && s_ready),
        .in_data   (s_data),
        .coef      (coef),
        .out_valid (fr_valid),
        .out_sum   (fr_sum),
        .out_rmag  (fr_rmag),
        .out_degen (fr_degen)
    );

    logic           sq_valid;
    logic [R_W-1:0] sq_root;
    logic [MW:0]    sq_side;

    sed_isqrt #(.S_W(S_W), .SIDE_W(MW + 1)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_rad    (fr_sum),
        .in_side   ({fr_degen, fr_rmag}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    logic              dv_valid;
    logic [DIST_W-1:0] dv_quot;
    logic              dv_sat;
    logic              dv_degen;

    sed_div #(.MW(MW), .R_W(R_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (sq_side[MW-1:0]),
        .in_den    (sq_root),
        .in_degen  (sq_side[MW]),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_sat   (dv_sat),
        .out_degen (dv_degen)
    );

    always_comb begin
        if (dv_degen) begin
            m_data_next.distance = '0;
        end else if (dv_sat) begin
            m_data_next.distance = DIST_MAX;
        end else begin
            m_data_next.distance = dv_quot;
        end
        m_data_next.inlier     = m_data_next.distance < thr_reg;
        m_data_next.degenerate = dv_degen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.distance == '0)
        else $error("degenerate result with nonzero distance");

    a_inlier_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.inlier == (m_data.distance < thr_reg))
        else $error("inlier flag disagrees with threshold");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

// File: rtl/sed_front.sv
// Front pipeline: epipolar lines, residual magnitude and gradient norm squared.
module sed_front
    import sed_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int S_W = 68 + 2 * COORD_BITS,
    localparam int MW  = 35 + 2 * COORD_BITS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  sed_in_t        in_data,
    input  coef_array_t    coef,
    output logic           out_valid,
    output logic [S_W-1:0] out_sum,
    output logic [MW-1:0]  out_rmag,
    output logic           out_degen
);
    localparam int C    = COORD_BITS;
    localparam int P_W  = 33 + C;
    localparam int A_W  = 34 + C;
    localparam int AM   = 33 + C;
    localparam int L    = A_W / 2;
    localparam int H    = A_W - L;
    localparam int PLW  = L + C;
    localparam int PHW  = H + C + 1;
    localparam int L2   = (AM + 1) / 2;
    localparam int H2   = AM - L2;
    localparam int SQW  = 2 * AM;
    localparam int RW   = 36 + 2 * C;

    logic [5:0] vld_reg;

    logic [C-1:0]      x1, y1, x2, y2;
    logic signed [C:0] x1s, y1s;

    assign x1  = C'(in_data.first_x);
    assign y1  = C'(in_data.first_y);
    assign x2  = C'(in_data.second_x);
    assign y2  = C'(in_data.second_y);
    assign x1s = $signed({1'b0, x1});
    assign y1s = $signed({1'b0, y1});

    // stage 1: coefficient times coordinate products
    logic signed [P_W-1:0] pa_next [3][3];
    logic signed [P_W-1:0] pa_reg  [3][3];
    logic signed [P_W-1:0] pb_next [2][3];
    logic signed [P_W-1:0] pb_reg  [2][3];
    logic [C-1:0]          x2_s1_reg, y2_s1_reg;
    logic signed [C:0]     x2s, y2s;

    assign x2s = $signed({1'b0, x2});
    assign y2s = $signed({1'b0, y2});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa_next[i][0] = P_W'($signed(coef[i*3+0]) * x1s);
            pa_next[i][1] = P_W'($signed(coef[i*3+1]) * y1s);
            pa_next[i][2] = P_W'($signed(coef[i*3+2])) <<< ONE_SHIFT;
        end
        for (int i = 0; i < 2; i++) begin
            pb_next[i][0] = P_W'($signed(coef[0*3+i]) * x2s);
            pb_next[i][1] = P_W'($signed(coef[1*3+i]) * y2s);
            pb_next[i][2] = P_W'($signed(coef[2*3+i])) <<< ONE_SHIFT;
        end
    end

    // stage 2: line sums
    logic signed [A_W-1:0] a_next [3];
    logic signed [A_W-1:0] a_reg  [3];
    logic signed [A_W-1:0] b_next [2];
    logic signed [A_W-1:0] b_reg  [2];
    logic [C-1:0]          x2_s2_reg, y2_s2_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_next[i] = A_W'(pa_reg[i][0]) + A_W'(pa_reg[i][1]) + A_W'(pa_reg[i][2]);
        end
        for (int i = 0; i < 2; i++) begin
            b_next[i] = A_W'(pb_reg[i][0]) + A_W'(pb_reg[i][1]) + A_W'(pb_reg[i][2]);
        end
    end

    // stage 3: magnitudes and residual partial products
    logic [AM-1:0]          mag_next [4];
    logic [AM-1:0]          mag_reg  [4];
    logic [PLW-1:0]         pl_next  [2];
    logic [PLW-1:0]         pl_reg   [2];
    logic signed [PHW-1:0]  ph_next  [2];
    logic signed [PHW-1:0]  ph_reg   [2];
    logic signed [A_W-1:0]  a2_reg;
    logic signed [A_W-1:0]  line_val [4];
    logic signed [C:0]      xr       [2];

    always_comb begin
        line_val[0] = a_reg[0];
        line_val[1] = a_reg[1];
        line_val[2] = b_reg[0];
        line_val[3] = b_reg[1];
        xr[0] = $signed({1'b0, x2_s2_reg});
        xr[1] = $signed({1'b0, y2_s2_reg});
        for (int k = 0; k < 4; k++) begin
            mag_next[k] = line_val[k][A_W-1] ? AM'(-line_val[k]) : AM'(line_val[k]);
        end
        for (int i = 0; i < 2; i++) begin
            pl_next[i] = PLW'(a_reg[i][L-1:0] * xr[i][C-1:0]);
            ph_next[i] = PHW'($signed(a_reg[i][A_W-1:L]) * xr[i]);
        end
    end

    // stage 4: square partial products and residual
    logic [2*L2-1:0]       ll_next [4];
    logic [2*L2-1:0]       ll_reg  [4];
    logic [L2+H2-1:0]      lh_next [4];
    logic [L2+H2-1:0]      lh_reg  [4];
    logic [2*H2-1:0]       hh_next [4];
    logic [2*H2-1:0]       hh_reg  [4];
    logic signed [RW-1:0]  r_next, r_reg;
    logic                  deg4_next, deg4_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ll_next[k] = (2*L2)'(mag_reg[k][L2-1:0] * mag_reg[k][L2-1:0]);
            lh_next[k] = (L2+H2)'(mag_reg[k][L2-1:0] * mag_reg[k][AM-1:L2]);
            hh_next[k] = (2*H2)'(mag_reg[k][AM-1:L2] * mag_reg[k][AM-1:L2]);
        end
        r_next = (RW'(ph_reg[0]) <<< L) + $signed(RW'(pl_reg[0]))
               + (RW'(ph_reg[1]) <<< L) + $signed(RW'(pl_reg[1]))
               + (RW'(a2_reg) <<< ONE_SHIFT);
        deg4_next = (mag_reg[0] == '0) && (mag_reg[1] == '0)
                 && (mag_reg[2] == '0) && (mag_reg[3] == '0);
    end

    // stage 5: squares and residual magnitude
    logic [SQW-1:0] sq_next [4];
    logic [SQW-1:0] sq_reg  [4];
    logic [MW-1:0]  rmag5_next, rmag5_reg;
    logic           deg5_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sq_next[k] = (SQW'(hh_reg[k]) << (2 * L2)) + (SQW'(lh_reg[k]) << (L2 + 1))
                       + SQW'(ll_reg[k]);
        end
        rmag5_next = r_reg[RW-1] ? MW'(-r_reg) : MW'(r_reg);
    end

    // stage 6: gradient norm squared
    logic [S_W-1:0] sum_next, sum_reg;
    logic [MW-1:0]  rmag6_reg;
    logic           deg6_reg;

    assign sum_next = S_W'(sq_reg[0]) + S_W'(sq_reg[1]) + S_W'(sq_reg[2]) + S_W'(sq_reg[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            x2_s1_reg <= x2;
            y2_s1_reg <= y2;
            a_reg     <= a_next;
            b_reg     <= b_next;
            x2_s2_reg <= x2_s1_reg;
            y2_s2_reg <= y2_s1_reg;
            mag_reg   <= mag_next;
            pl_reg    <= pl_next;
            ph_reg    <= ph_next;
            a2_reg    <= a_reg[2];
            ll_reg    <= ll_next;
            lh_reg    <= lh_next;
            hh_reg    <= hh_next;
            r_reg     <= r_next;
            deg4_reg  <= deg4_next;
            sq_reg    <= sq_next;
            rmag5_reg <= rmag5_next;
            deg5_reg  <= deg4_reg;
            sum_reg   <= sum_next;
            rmag6_reg <= rmag5_reg;
            deg6_reg  <= deg5_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_sum   = sum_reg;
    assign out_rmag  = rmag6_reg;
    assign out_degen = deg6_reg;

endmodule

// File: rtl/sed_isqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
module sed_isqrt
    import sed_pkg::*;
#(
    parameter int S_W    = 100,
    parameter int SIDE_W = 68,
    localparam int R_W   = S_W / 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [S_W-1:0]    in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [R_W-1:0]    out_root,
    output logic [SIDE_W-1:0] out_side
);
    logic [R_W-1:0]    vld_reg;
    logic [R_W+1:0]    rem_reg  [R_W];
    logic [R_W-1:0]    root_reg [R_W];
    logic [S_W-1:0]    rad_reg  [R_W];
    logic [SIDE_W-1:0] side_reg [R_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[R_W-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < R_W; k++) begin : g_step
        logic [R_W+1:0]    rem_in;
        logic [R_W-1:0]    root_in;
        logic [S_W-1:0]    rad_in;
        logic [SIDE_W-1:0] side_in;
        logic [R_W+3:0]    rem_sh, trial, diff;
        logic              ge;
        logic [R_W+1:0]    rem_next;
        logic [R_W-1:0]    root_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign side_in = in_side;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign rem_sh    = {rem_in, rad_in[S_W-1:S_W-2]};
        assign trial     = {2'b00, root_in, 2'b01};
        assign diff      = rem_sh - trial;
        assign ge        = rem_sh >= trial;
        assign rem_next  = ge ? diff[R_W+1:0] : rem_sh[R_W+1:0];
        assign root_next = {root_in[R_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_in << 2;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[R_W-1];
    assign out_root  = root_reg[R_W-1];
    assign out_side  = side_reg[R_W-1];

endmodule

// File: rtl/sed_div.sv
// Pipelined saturating 16-bit quotient of residual magnitude over root norm.
module sed_div
    import sed_pkg::*;
#(
    parameter int MW  = 67,
    parameter int R_W = 50
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [MW-1:0]     in_num,
    input  logic [R_W-1:0]    in_den,
    input  logic              in_degen,
    output logic              out_valid,
    output logic [DIST_W-1:0] out_quot,
    output logic              out_sat,
    output logic              out_degen
);
    localparam int CW = (MW > R_W + DIST_W) ? MW : R_W + DIST_W;
    localparam int NS = DIST_W + 1;

    logic [NS-1:0]     vld_reg;
    logic [MW-1:0]     rem_reg  [NS];
    logic [R_W-1:0]    den_reg  [NS];
    logic [DIST_W-1:0] q_reg    [NS];
    logic              sat_reg  [NS];
    logic              deg_reg  [NS];

    logic [CW-1:0] scaled;
    logic          sat_next;

    assign scaled   = (CW'(in_den) << DIST_W) - CW'(in_den);
    assign sat_next = scaled <= CW'(in_num);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= in_num;
            den_reg[0] <= in_den;
            q_reg[0]   <= '0;
            sat_reg[0] <= sat_next;
            deg_reg[0] <= in_degen;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_bit
        logic [CW-1:0]     t, diff;
        logic              ge;
        logic [MW-1:0]     rem_next;
        logic [DIST_W-1:0] q_next;

        assign t        = CW'(den_reg[k-1]) << (DIST_W - k);
        assign diff     = CW'(rem_reg[k-1]) - t;
        assign ge       = t <= CW'(rem_reg[k-1]);
        assign rem_next = ge ? MW'(diff) : rem_reg[k-1];
        assign q_next   = {q_reg[k-1][DIST_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= q_next;
                sat_reg[k] <= sat_reg[k-1];
                deg_reg[k] <= deg_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_quot  = q_reg[NS-1];
    assign out_sat   = sat_reg[NS-1];
    assign out_degen = deg_reg[NS-1];

endmodule
